// ----- sv/mts_pkg.sv -----
// ----------------------------------------------------------------------------
// mts_pkg: shared types and codes for the max tracking stack
// Action and status codes, and the shift control passed along the cell row.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned STATUS_W = 2;

  localparam logic ACTION_PUSH = 1'b0;
  localparam logic ACTION_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage

// ----- sv/mts_cell.sv -----
// ----------------------------------------------------------------------------
// mts_cell: one stack slot
// Holds a value with the running maximum and its position below it. On push
// it takes the entry of the slot above, on pop the entry of the slot below.
// ----------------------------------------------------------------------------
module mts_cell
  import mts_pkg::*;
#(
  parameter int unsigned PosW = 6
) (
  input  logic                     clk,
  input  shift_ctl_t               ctl,
  input  logic signed [DATA_W-1:0] upper_value,
  input  logic signed [DATA_W-1:0] upper_max,
  input  logic        [PosW-1:0]   upper_pos,
  input  logic signed [DATA_W-1:0] lower_value,
  input  logic signed [DATA_W-1:0] lower_max,
  input  logic        [PosW-1:0]   lower_pos,
  output logic signed [DATA_W-1:0] value,
  output logic signed [DATA_W-1:0] max_value,
  output logic        [PosW-1:0]   max_pos
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      value     <= upper_value;
      max_value <= upper_max;
      max_pos   <= upper_pos;
    end else if (ctl.pop) begin
      value     <= lower_value;
      max_value <= lower_max;
      max_pos   <= lower_pos;
    end
  end

endmodule

// ----- sv/max_tracking_stack.sv -----
// ----------------------------------------------------------------------------
// max_tracking_stack: LIFO of signed 32-bit values with running maximum
// Push/pop stack built as a row of shifting cells; every transfer returns the
// popped value, the new top, the maximum, its position and the fill count.
// ----------------------------------------------------------------------------
// One input transfer can be taken every cycle; its result is registered and
// appears the cycle after acceptance. The top of the stack is always cell 0 of
// a row of STACK_DEPTH cells that shift down on push and up on pop, so each
// cell carries the maximum of itself and everything below it, and only the
// two top cells are ever looked at. Input ready drops only while a result
// waits in the output register and the sink is not ready. A pop on an empty
// stack or a push on a full one reports its status and leaves the stack as is.
// ----------------------------------------------------------------------------
module max_tracking_stack
  import mts_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64,
  localparam int unsigned PosW = $clog2(STACK_DEPTH),
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     action,
  input  logic signed [DATA_W-1:0] push_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] popped_value,
  output logic signed [DATA_W-1:0] top_value,
  output logic signed [DATA_W-1:0] max_value,
  output logic        [PosW-1:0]   max_position,
  output logic        [CntW-1:0]   fill_count,
  output logic        [STATUS_W-1:0] status
);

  logic signed [DATA_W-1:0] cell_val [STACK_DEPTH];
  logic signed [DATA_W-1:0] cell_max [STACK_DEPTH];
  logic        [PosW-1:0]   cell_pos [STACK_DEPTH];

  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;

  logic in_fire, is_push, full, empty, push_ok, pop_ok, keep_old;
  logic signed [DATA_W-1:0] new_max;
  logic        [PosW-1:0]   new_pos;
  shift_ctl_t ctl;

  logic signed [DATA_W-1:0] popped_next, top_next, max_next;
  logic        [PosW-1:0]   pos_next;
  status_t                  status_next;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_push  = (action == ACTION_PUSH);
  assign full     = (count == CntW'(STACK_DEPTH));
  assign empty    = (count == '0);
  assign push_ok  = is_push && !full;
  assign pop_ok   = !is_push && !empty;
  assign keep_old = !empty && (cell_max[0] > push_value);
  assign new_max  = keep_old ? cell_max[0] : push_value;
  assign new_pos  = keep_old ? cell_pos[0] : count[PosW-1:0];

  assign ctl.push = in_fire && push_ok;
  assign ctl.pop  = in_fire && pop_ok;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    localparam int unsigned Up = (i == 0) ? 0 : i - 1;
    localparam int unsigned Dn = (i == STACK_DEPTH - 1) ? i : i + 1;
    logic signed [DATA_W-1:0] up_val, up_max;
    logic        [PosW-1:0]   up_pos;

    if (i == 0) begin : g_head
      assign up_val = push_value;
      assign up_max = new_max;
      assign up_pos = new_pos;
    end else begin : g_body
      assign up_val = cell_val[Up];
      assign up_max = cell_max[Up];
      assign up_pos = cell_pos[Up];
    end

    mts_cell #(
      .PosW(PosW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .upper_value(up_val),
      .upper_max  (up_max),
      .upper_pos  (up_pos),
      .lower_value(cell_val[Dn]),
      .lower_max  (cell_max[Dn]),
      .lower_pos  (cell_pos[Dn]),
      .value      (cell_val[i]),
      .max_value  (cell_max[i]),
      .max_pos    (cell_pos[i])
    );
  end

  always_comb begin
    popped_next = '0;
    top_next    = '0;
    max_next    = '0;
    pos_next    = '0;
    status_next = STATUS_OK;
    count_next  = count;
    if (push_ok) begin
      top_next   = push_value;
      max_next   = new_max;
      pos_next   = new_pos;
      count_next = count + 1'b1;
    end else if (pop_ok) begin
      popped_next = cell_val[0];
      count_next  = count - 1'b1;
      if (count > CntW'(1)) begin
        top_next = cell_val[1];
        max_next = cell_max[1];
        pos_next = cell_pos[1];
      end
    end else begin
      status_next = is_push ? STATUS_OVERFLOW : STATUS_UNDERFLOW;
      if (!empty) begin
        top_next = cell_val[0];
        max_next = cell_max[0];
        pos_next = cell_pos[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_fire) begin
      popped_value <= popped_next;
      top_value    <= top_next;
      max_value    <= max_next;
      max_position <= pos_next;
      fill_count   <= count_next;
      status       <= status_next;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(STACK_DEPTH))
    else $error("fill count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.push |=> (count == $past(count) + 1'b1))
    else $error("push did not grow the stack");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_UNDERFLOW) |-> (fill_count == '0))
    else $error("underflow reported on a non-empty stack");

  a_error_holds: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !push_ok && !pop_ok) |=> $stable(count))
    else $error("rejected transfer changed the stack");
`endif

endmodule

// ----- tb/sv/max_tracking_stack_tb.sv -----
// ----------------------------------------------------------------------------
// max_tracking_stack_tb: self-checking bench for the max tracking stack
// Drives push/pop transfers from a queue, tracks the stack and its running
// maximum in a local shadow copy, and checks every result transfer field by
// field. It runs three idle/stall phases and includes fill-to-overflow and
// drain-to-underflow sequences.
// ----------------------------------------------------------------------------
module max_tracking_stack_tb;
  import mts_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned POS_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic             act;
    logic [DATA_W-1:0] val;
    bit               hold;
  } stack_cmd_t;

  typedef struct {
    logic signed [DATA_W-1:0] popped;
    logic signed [DATA_W-1:0] top;
    logic signed [DATA_W-1:0] maxv;
    logic [POS_W-1:0]         max_pos;
    logic [CNT_W-1:0]         fill;
    status_t                  status;
  } stack_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = ACTION_PUSH;
  logic signed [DATA_W-1:0] push_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] popped_value;
  logic signed [DATA_W-1:0] top_value;
  logic signed [DATA_W-1:0] max_value;
  logic [POS_W-1:0] max_position;
  logic [CNT_W-1:0] fill_count;
  logic [STATUS_W-1:0] status;

  max_tracking_stack #(.STACK_DEPTH(DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .push_value(push_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .popped_value(popped_value), .top_value(top_value),
    .max_value(max_value), .max_position(max_position),
    .fill_count(fill_count), .status(status)
  );

  stack_cmd_t    cmd_q[$];
  stack_result_t result_q[$];
  stack_cmd_t    next_cmd;
  stack_result_t exp_r;

  // shadow stack
  logic signed [DATA_W-1:0] shadow_vals[DEPTH];
  logic signed [DATA_W-1:0] shadow_max[DEPTH];
  logic [POS_W-1:0]         shadow_pos[DEPTH];
  int unsigned              shadow_depth = 0;

  int unsigned send_idle_pct = 27;
  int unsigned recv_stall_pct = 54;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          in_done = 1'b0;

  // generator bookkeeping
  int unsigned gen_depth = 0;
  int unsigned gen_count = 0;
  logic [DATA_W-1:0] last_val = '0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic stack_result_t apply_stack_op(logic act, logic signed [DATA_W-1:0] val);
    stack_result_t r;
    int unsigned d;
    r.popped = '0;
    r.top = '0;
    r.maxv = '0;
    r.max_pos = '0;
    r.status = STATUS_OK;
    d = shadow_depth;
    if (act == ACTION_PUSH) begin
      if (d >= DEPTH) begin
        r.status = STATUS_OVERFLOW;
      end else begin
        shadow_vals[d] = val;
        if (d > 0 && shadow_max[d-1] > val) begin
          shadow_max[d] = shadow_max[d-1];
          shadow_pos[d] = shadow_pos[d-1];
        end else begin
          shadow_max[d] = val;
          shadow_pos[d] = POS_W'(d);
        end
        shadow_depth = d + 1;
      end
    end else if (d == 0) begin
      r.status = STATUS_UNDERFLOW;
    end else begin
      shadow_depth = d - 1;
      r.popped = shadow_vals[d-1];
    end
    if (shadow_depth > 0) begin
      r.top = shadow_vals[shadow_depth-1];
      r.maxv = shadow_max[shadow_depth-1];
      r.max_pos = shadow_pos[shadow_depth-1];
    end
    r.fill = CNT_W'(shadow_depth);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic add_cmd(logic act, logic [DATA_W-1:0] val, bit hold);
    stack_cmd_t c;
    c.act = act;
    c.val = val;
    c.hold = hold;
    cmd_q.push_back(c);
    gen_count++;
    if (act == ACTION_PUSH) begin
      last_val = val;
      if (gen_depth < DEPTH) gen_depth++;
    end else if (gen_depth > 0) begin
      gen_depth--;
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(16) - 32'd8;
      4, 5, 6:    return $urandom;
      7:          return 32'h7fff_ffff;
      8:          return 32'h8000_0000;
      default:    return last_val;
    endcase
  endfunction

  task automatic gen_phase(int unsigned n);
    int unsigned target;
    int unsigned run_len;
    int unsigned push_pct;
    int unsigned extra;
    target = gen_count + n;
    while (gen_count < target) begin
      case ($urandom_range(9))
        0: begin
          while (gen_depth < DEPTH) add_cmd(ACTION_PUSH, pick_value(), 1'b0);
          extra = $urandom_range(1, 3);
          repeat (extra) add_cmd(ACTION_PUSH, pick_value(), 1'b0);
        end
        1: begin
          while (gen_depth > 0) add_cmd(ACTION_POP, $urandom, 1'b0);
          extra = $urandom_range(1, 2);
          repeat (extra) add_cmd(ACTION_POP, $urandom, 1'b0);
        end
        default: begin
          run_len = $urandom_range(8, 40);
          push_pct = $urandom_range(20, 80);
          repeat (run_len) begin
            if ($urandom_range(99) < push_pct)
              add_cmd(ACTION_PUSH, pick_value(), $urandom_range(49) == 0);
            else
              add_cmd(ACTION_POP, $urandom, $urandom_range(49) == 0);
          end
        end
      endcase
    end
  endtask

  task automatic wait_idle();
    while (cmd_q.size() > 0 || result_q.size() > 0 || in_valid) @(posedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_done) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct &&
            !(cmd_q[0].hold && result_q.size() > 0)) begin
          next_cmd = cmd_q.pop_front();
          action <= next_cmd.act;
          push_value <= next_cmd.val;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    in_done <= !rst && in_valid && in_ready;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("result with nothing pending", popped_value, '0);
        end else begin
          exp_r = result_q.pop_front();
          if (popped_value !== exp_r.popped)
            report_mismatch("popped_value", popped_value, exp_r.popped);
          if (top_value !== exp_r.top)
            report_mismatch("top_value", top_value, exp_r.top);
          if (max_value !== exp_r.maxv)
            report_mismatch("max_value", max_value, exp_r.maxv);
          if (max_position !== exp_r.max_pos)
            report_mismatch("max_position", DATA_W'(max_position), DATA_W'(exp_r.max_pos));
          if (fill_count !== exp_r.fill)
            report_mismatch("fill_count", DATA_W'(fill_count), DATA_W'(exp_r.fill));
          if (status !== exp_r.status)
            report_mismatch("status", DATA_W'(status), DATA_W'(exp_r.status));
        end
      end
      if (in_valid && in_ready)
        result_q.push_back(apply_stack_op(action, push_value));
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    // directed: underflow, extremes, ties, drain to empty, bit patterns
    add_cmd(ACTION_POP, 32'h0, 1'b0);
    add_cmd(ACTION_PUSH, 32'h8000_0000, 1'b0);
    add_cmd(ACTION_PUSH, 32'h8000_0000, 1'b0);
    add_cmd(ACTION_PUSH, 32'd5, 1'b0);
    add_cmd(ACTION_PUSH, 32'd5, 1'b0);
    add_cmd(ACTION_PUSH, 32'd3, 1'b0);
    add_cmd(ACTION_PUSH, 32'h7fff_ffff, 1'b0);
    add_cmd(ACTION_PUSH, 32'hffff_ffff, 1'b0);
    add_cmd(ACTION_PUSH, 32'h0, 1'b0);
    add_cmd(ACTION_POP, 32'hffff_ffff, 1'b1);
    add_cmd(ACTION_POP, 32'h0, 1'b0);
    add_cmd(ACTION_POP, 32'h0, 1'b0);
    add_cmd(ACTION_POP, 32'h0, 1'b0);
    add_cmd(ACTION_POP, 32'h0, 1'b0);
    add_cmd(ACTION_POP, 32'h0, 1'b0);
    add_cmd(ACTION_POP, 32'h0, 1'b0);
    add_cmd(ACTION_POP, 32'h0, 1'b0);
    add_cmd(ACTION_PUSH, 32'haaaa_aaaa, 1'b0);
    add_cmd(ACTION_PUSH, 32'h5555_5555, 1'b0);
    add_cmd(ACTION_PUSH, 32'haaaa_aaaa, 1'b0);
    add_cmd(ACTION_POP, 32'h0, 1'b0);
    add_cmd(ACTION_POP, 32'h0, 1'b0);
    add_cmd(ACTION_POP, 32'h0, 1'b0);
    gen_phase(400);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait_idle();
    send_idle_pct = 54;
    recv_stall_pct = 27;
    gen_phase(420);
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    gen_phase(420);
    wait_idle();
    repeat (8) @(posedge clk);

    if (mismatches == 0 && result_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
